[sv/page_frame_bitmap_allocator_assert.svh]
// Assertion macros used by the checker of the page frame allocator.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PFBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfba: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define PFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfba: next-cycle check failed");

`endif

[sv/pfba_pkg.sv]
// Package of the page frame allocator: codes, defaults, state type and helpers.
`default_nettype none

package pfba_pkg;

    // default parameter values
    localparam int MAX_PAGES_DEF  = 32768;
    localparam int PAGE_SHIFT_DEF = 12;

    // reset values
    localparam logic [15:0] RESET_TOTAL = 16'd32768;
    localparam logic [15:0] RESET_USED  = 16'd32768;
    localparam logic [31:0] ALL_USED    = 32'hFFFF_FFFF;

    // request codes
    localparam logic [1:0] REQ_INIT      = 2'd0;
    localparam logic [1:0] REQ_FREE_RGN  = 2'd1;
    localparam logic [1:0] REQ_ALLOC     = 2'd2;
    localparam logic [1:0] REQ_FREE_PAGE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // register index of total_pages
    localparam logic REG_TOTAL_PAGES = 1'b0;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_FPREP,
        S_FSET,
        S_FREG,
        S_ASCAN,
        S_ACHK,
        S_RESP
    } t_state;

    // index of the lowest clear bit of a map word
    function automatic logic [4:0] lowest_zero(input logic [31:0] d);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (!d[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/pfba_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module pfba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[sv/page_frame_bitmap_allocator.sv]
// Reset: synchronous, active low; the map is then filled with ones, one word a cycle,
// and no request word is accepted during the sweep.
// One request at a time. Free page and free region: clip to the managed range, set the
// word bounds, then read each map word touched and write back the previous one. Allocate:
// read and check map words from the lowest-free-word hint, skipping full words.
// Init: the fill sweep. All bounded by the one map RAM port pair.
`default_nettype none

module page_frame_bitmap_allocator #(
    parameter int MAX_PAGES  = pfba_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = pfba_pkg::PAGE_SHIFT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,  // [31:0] byte_address, [63:32] region_bytes
    input  wire logic [1:0]  i_s_axis_tuser,  // [1:0] req_type
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [47:0] o_m_axis_tdata,  // [31:0] page_address, [47:32] pages_in_use
    output logic      [1:0]  o_m_axis_tuser,  // [1:0] status
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int MAP_WORDS = MAX_PAGES / 32;
    localparam int WAW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WCW = $clog2(MAP_WORDS + 1);
    localparam int FPW = 32 - PAGE_SHIFT;
    localparam int EW  = FPW + 1;
    localparam int XW  = (WCW + 5 > EW) ? WCW + 5 : EW;
    localparam int PAW = WCW + 5 + PAGE_SHIFT;

    // control state
    pfba_pkg::t_state r_state, n_state;
    logic [15:0]      r_total;
    logic [15:0]      r_used,   n_used;
    logic [WCW-1:0]   r_hint,   n_hint;
    logic [WCW-1:0]   r_w,      n_w;
    logic             r_issued, n_issued;
    logic             r_rdv,    n_rdv;
    logic             r_init,   n_init;
    logic             r_ovalid, n_ovalid;

    // payload
    logic [FPW-1:0]   r_first,  n_first;
    logic [FPW-1:0]   r_count,  n_count;
    logic [15:0]      r_stop,   n_stop;
    logic [15:0]      r_lastp,  n_lastp;
    logic [WCW-1:0]   r_fw,     n_fw;
    logic [WCW-1:0]   r_lw,     n_lw;
    logic [WCW-1:0]   r_wq,     n_wq;
    logic [1:0]       r_status, n_status;
    logic [31:0]      r_addr,   n_addr;
    logic [1:0]       r_ostat,  n_ostat;
    logic [31:0]      r_oaddr,  n_oaddr;
    logic [15:0]      r_oused,  n_oused;

    // map RAM ports
    logic             w_we, w_re;
    logic [WAW-1:0]   w_waddr, w_raddr;
    logic [31:0]      w_wdata, w_rdata;

    // shared conditions
    logic [15:0]      w_n;
    logic             w_accept, w_fill_last, w_scan_end, w_word_full;
    logic             w_page_oob, w_freg_done, w_out_free, w_any;
    logic [4:0]       w_bit;
    logic [WCW+4:0]   w_page;
    logic [EW-1:0]    w_end;
    logic [4:0]       w_lo, w_hi;
    logic [31:0]      w_mask;
    logic [15:0]      w_dec;
    logic             w_cfg_wr;

    pfba_ram #(
        .WIDTH (32),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == pfba_pkg::REG_TOTAL_PAGES);
    assign prdata   = (paddr[2] == pfba_pkg::REG_TOTAL_PAGES) ? {16'd0, r_total} : 32'd0;

    // managed page count, limited to the map size
    always_comb begin
        if ({16'd0, r_total} > 32'(MAX_PAGES)) begin
            w_n = 16'(MAX_PAGES);
        end else begin
            w_n = r_total;
        end
    end

    // shared conditions
    assign o_s_axis_tready = (r_state == pfba_pkg::S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_fill_last     = (r_w == WCW'(MAP_WORDS - 1));
    assign w_scan_end      = (XW'({r_w, 5'b00000}) >= XW'(w_n));
    assign w_word_full     = (w_rdata == pfba_pkg::ALL_USED);
    assign w_bit           = pfba_pkg::lowest_zero(w_rdata);
    assign w_page          = {r_w, w_bit};
    assign w_page_oob      = (XW'(w_page) >= XW'(w_n));
    assign w_freg_done     = r_issued && r_rdv;
    assign w_out_free      = !r_ovalid || i_m_axis_tready;
    assign w_end           = EW'(r_first) + EW'(r_count);
    assign w_any           = (EW'(r_first) < EW'(r_stop));

    // clear mask of the word being written back
    assign w_lo   = (r_wq == r_fw) ? r_first[4:0] : 5'd0;
    assign w_hi   = (r_wq == r_lw) ? r_lastp[4:0] : 5'd31;
    assign w_mask = (32'hFFFF_FFFF << w_lo) & (32'hFFFF_FFFF >> (5'd31 - w_hi));
    assign w_dec  = r_stop - 16'(r_first);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfba_pkg::S_FILL: begin
                if (w_fill_last) begin
                    n_state = r_init ? pfba_pkg::S_RESP : pfba_pkg::S_IDLE;
                end
            end
            pfba_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_s_axis_tuser)
                        pfba_pkg::REQ_INIT:  n_state = pfba_pkg::S_FILL;
                        pfba_pkg::REQ_ALLOC: n_state = pfba_pkg::S_ASCAN;
                        default:             n_state = pfba_pkg::S_FPREP;
                    endcase
                end
            end
            pfba_pkg::S_FPREP: n_state = pfba_pkg::S_FSET;
            pfba_pkg::S_FSET:  n_state = w_any ? pfba_pkg::S_FREG : pfba_pkg::S_RESP;
            pfba_pkg::S_FREG: begin
                if (w_freg_done) begin
                    n_state = pfba_pkg::S_RESP;
                end
            end
            pfba_pkg::S_ASCAN: n_state = w_scan_end ? pfba_pkg::S_RESP : pfba_pkg::S_ACHK;
            pfba_pkg::S_ACHK:  n_state = w_word_full ? pfba_pkg::S_ASCAN : pfba_pkg::S_RESP;
            pfba_pkg::S_RESP: begin
                if (w_out_free) begin
                    n_state = pfba_pkg::S_IDLE;
                end
            end
            default: n_state = pfba_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_used   = r_used;
        n_hint   = r_hint;
        n_w      = r_w;
        n_issued = r_issued;
        n_rdv    = r_rdv;
        n_init   = r_init;
        n_first  = r_first;
        n_count  = r_count;
        n_stop   = r_stop;
        n_lastp  = r_lastp;
        n_fw     = r_fw;
        n_lw     = r_lw;
        n_wq     = r_wq;
        n_status = r_status;
        n_addr   = r_addr;
        n_ostat  = r_ostat;
        n_oaddr  = r_oaddr;
        n_oused  = r_oused;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        w_we     = 1'b0;
        w_waddr  = r_w[WAW-1:0];
        w_wdata  = pfba_pkg::ALL_USED;
        w_re     = 1'b0;
        w_raddr  = r_w[WAW-1:0];

        unique case (r_state)
            // fill sweep after reset and on init
            pfba_pkg::S_FILL: begin
                w_we = 1'b1;
                if (w_fill_last) begin
                    n_hint = WCW'(MAP_WORDS);
                    n_w    = '0;
                    if (r_init) begin
                        n_used = w_n;
                    end
                end else begin
                    n_w = r_w + WCW'(1);
                end
            end
            // take a request
            pfba_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_status = pfba_pkg::ST_OK;
                    n_addr   = 32'd0;
                    n_first  = FPW'(i_s_axis_tdata[31:0] >> PAGE_SHIFT);
                    if (i_s_axis_tuser == pfba_pkg::REQ_FREE_PAGE) begin
                        n_count = FPW'(1);
                    end else begin
                        n_count = FPW'(i_s_axis_tdata[63:32] >> PAGE_SHIFT);
                    end
                    n_init = 1'b1;
                    if (i_s_axis_tuser == pfba_pkg::REQ_INIT) begin
                        n_w = '0;
                    end else begin
                        n_w = r_hint;
                    end
                end
            end
            // clip the region to the managed range
            pfba_pkg::S_FPREP: begin
                if (w_end > EW'(w_n)) begin
                    n_stop   = w_n;
                    n_status = pfba_pkg::ST_RANGE;
                end else begin
                    n_stop = 16'(w_end);
                end
            end
            // word bounds of the region
            pfba_pkg::S_FSET: begin
                n_fw     = WCW'(r_first >> 5);
                n_w      = WCW'(r_first >> 5);
                n_lastp  = r_stop - 16'd1;
                n_lw     = WCW'((r_stop - 16'd1) >> 5);
                n_issued = 1'b0;
                n_rdv    = 1'b0;
            end
            // read one word, write back the previous one
            pfba_pkg::S_FREG: begin
                if (!r_issued) begin
                    w_re     = 1'b1;
                    n_wq     = r_w;
                    n_issued = (r_w == r_lw);
                    if (r_w != r_lw) begin
                        n_w = r_w + WCW'(1);
                    end
                end
                n_rdv = !r_issued;
                if (r_rdv) begin
                    w_we    = 1'b1;
                    w_waddr = r_wq[WAW-1:0];
                    w_wdata = w_rdata & ~w_mask;
                end
                if (w_freg_done) begin
                    n_used = (r_used > w_dec) ? r_used - w_dec : 16'd0;
                    if (r_fw < r_hint) begin
                        n_hint = r_fw;
                    end
                end
            end
            // scan from the hint for a word with a clear bit
            pfba_pkg::S_ASCAN: begin
                if (w_scan_end) begin
                    n_status = pfba_pkg::ST_OOM;
                end else begin
                    w_re = 1'b1;
                end
            end
            pfba_pkg::S_ACHK: begin
                if (w_word_full) begin
                    n_w    = r_w + WCW'(1);
                    n_hint = r_w + WCW'(1);
                end else if (w_page_oob) begin
                    n_status = pfba_pkg::ST_OOM;
                end else begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata | (32'd1 << w_bit);
                    n_hint  = r_w;
                    n_addr  = 32'(PAW'(w_page) << PAGE_SHIFT);
                    if (r_used != 16'hFFFF) begin
                        n_used = r_used + 16'd1;
                    end
                end
            end
            // hand the result to the output register
            pfba_pkg::S_RESP: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_status;
                    n_oaddr  = r_addr;
                    n_oused  = r_used;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pfba_pkg::S_FILL;
            r_total  <= pfba_pkg::RESET_TOTAL;
            r_used   <= pfba_pkg::RESET_USED;
            r_hint   <= WCW'(MAP_WORDS);
            r_w      <= '0;
            r_issued <= 1'b0;
            r_rdv    <= 1'b0;
            r_init   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_hint   <= n_hint;
            r_w      <= n_w;
            r_issued <= n_issued;
            r_rdv    <= n_rdv;
            r_init   <= n_init;
            r_ovalid <= n_ovalid;
            if (w_cfg_wr) begin
                r_total <= pwdata[15:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_count  <= n_count;
        r_stop   <= n_stop;
        r_lastp  <= n_lastp;
        r_fw     <= n_fw;
        r_lw     <= n_lw;
        r_wq     <= n_wq;
        r_status <= n_status;
        r_addr   <= n_addr;
        r_ostat  <= n_ostat;
        r_oaddr  <= n_oaddr;
        r_oused  <= n_oused;
    end

    // result stream
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_oused, r_oaddr};
    assign o_m_axis_tuser  = r_ostat;

endmodule

`default_nettype wire

[sv/pfba_checker.sv]
// Port-level checker of the page frame allocator and its bind to the top level.
`default_nettype none

`include "page_frame_bitmap_allocator_assert.svh"

module pfba_checker #(
    parameter int PAGE_SHIFT = pfba_pkg::PAGE_SHIFT_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [47:0] o_m_axis_tdata,  // [31:0] page_address, [47:32] pages_in_use
    input wire logic [1:0]  o_m_axis_tuser   // [1:0] status
);

    // a stalled result word stays offered and unchanged
    `PFBA_ASSERT_NEXT(a_out_hold_valid, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    `PFBA_ASSERT_NEXT(a_out_hold_data, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // only a successful allocation carries an address
    `PFBA_ASSERT_SAME(a_fail_no_addr, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser != pfba_pkg::ST_OK), o_m_axis_tdata[31:0] == 32'd0)

    // returned addresses are page aligned
    `PFBA_ASSERT_SAME(a_addr_aligned, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[PAGE_SHIFT-1:0] == '0)

endmodule

bind page_frame_bitmap_allocator pfba_checker #(
    .PAGE_SHIFT (PAGE_SHIFT)
) u_pfba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

[test/tb_page_frame_bitmap_allocator.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the bitmap page frame allocator: directed table, then random phases.
module tb_page_frame_bitmap_allocator;
    import pfba_pkg::*;

    localparam int MAP_WORDS   = MAX_PAGES_DEF / 32;
    localparam int PG_SHIFT    = PAGE_SHIFT_DEF;
    localparam int DIR_ROWS    = 20;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 55;
    localparam int HOLD_AFTER  = 200;
    localparam int HOLD_CYCLES = 300;
    // margin for an init, a full region sweep or a deep scan over every map word
    localparam int DRAIN_WAIT  = 2 * MAP_WORDS + 64;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] page_addr;
        logic [15:0] in_use;
    } alloc_resp_t;

    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] addr;
        logic [31:0] len;
        logic        known;
        alloc_resp_t resp;
    } req_row_t;

    // DUT inputs, known from time zero
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [63:0] s_data  = '0;    // [31:0] byte_address, [63:32] region_bytes
    logic [1:0]  s_user  = '0;    // [1:0] req_type
    logic        m_ready = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;

    // DUT outputs
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata;  // [31:0] page_address, [47:32] pages_in_use
    logic [1:0]  o_m_axis_tuser;  // [1:0] status
    logic [31:0] prdata;
    logic        pready;

    page_frame_bitmap_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Shadow copy of the allocator state
    logic [31:0] frame_map [MAP_WORDS];
    logic [15:0] frames_used;
    logic [15:0] total_pages_reg;

    alloc_resp_t pending_resp [$];
    int unsigned held_pages [$];

    int          mismatches   = 0;
    int unsigned sent_total   = 0;
    int unsigned words_seen   = 0;
    int unsigned req_hits [4] = '{0, 0, 0, 0};
    int unsigned alloc_ok     = 0;
    int unsigned alloc_oom    = 0;
    int unsigned range_hits   = 0;
    bit          held_once    = 1'b0;
    bit          send_calm    = 1'b0;
    bit          recv_calm    = 1'b0;

    // Directed requests; expected words typed in only where obvious
    req_row_t directed_rows [DIR_ROWS] = '{
        '{REQ_ALLOC,     32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OOM,   32'h0, 16'd32768}},
        '{REQ_FREE_PAGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_RANGE, 32'h0, 16'd32768}},
        '{REQ_FREE_RGN,  32'h0000_0000, 32'h0000_0FFF, 1'b1, '{ST_OK,    32'h0, 16'd32768}},
        '{REQ_FREE_RGN,  32'h0000_0000, 32'h0000_2000, 1'b1, '{ST_OK,    32'h0, 16'd32766}},
        '{REQ_ALLOC,     32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OK,    32'h0, 16'd32767}},
        '{REQ_ALLOC,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h1000, 16'd32768}},
        '{REQ_ALLOC,     32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OOM,   32'h0, 16'd32768}},
        '{REQ_FREE_PAGE, 32'h0000_5ABC, 32'h0000_0000, 1'b0, '0},
        '{REQ_FREE_PAGE, 32'h0000_5000, 32'h0000_0000, 1'b0, '0},   // already free
        '{REQ_ALLOC,     32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{REQ_FREE_RGN,  32'h07FF_F000, 32'hFFFF_FFFF, 1'b0, '0},   // last page, runs past
        '{REQ_ALLOC,     32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{REQ_FREE_RGN,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{REQ_FREE_RGN,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},   // count to zero
        '{REQ_FREE_PAGE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},   // count stays at zero
        '{REQ_ALLOC,     32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{REQ_ALLOC,     32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{REQ_INIT,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'h0, 16'd32768}},
        '{REQ_FREE_RGN,  32'h0000_1FFF, 32'h0000_1FFF, 1'b0, '0},
        '{REQ_ALLOC,     32'h0000_0000, 32'h0000_0000, 1'b0, '0}
    };

    // total_pages per phase: extremes, partial last words, one random value
    logic [15:0] phase_pages [PHASES] = '{
        16'd0, 16'd1, 16'hFFFF, 16'd33, 16'd64, 16'd100,
        16'd31, 16'd1000, 16'd32767, 16'd0, 16'd32768
    };

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("tb_page_frame_bitmap_allocator: errors");
        $finish;
    end

    function automatic int unsigned managed_count();
        return (total_pages_reg > MAX_PAGES_DEF) ? MAX_PAGES_DEF : total_pages_reg;
    endfunction

    function automatic void release_frame(int unsigned pg);
        frame_map[(pg >> 5) % MAP_WORDS][pg[4:0]] = 1'b0;
        if (frames_used != 16'd0)
            frames_used--;
    endfunction

    // Apply one request to the shadow state and return the expected result word
    function automatic alloc_resp_t serve_request(logic [1:0] req, logic [31:0] addr,
                                                  logic [31:0] len);
        alloc_resp_t r;
        int unsigned n;
        int unsigned first;
        int unsigned last;
        int unsigned stop;
        int unsigned pg;
        bit          hit;
        r = '0;
        n = managed_count();
        hit = 1'b0;
        case (req)
            REQ_INIT: begin
                for (int w = 0; w < MAP_WORDS; w++)
                    frame_map[w] = ALL_USED;
                frames_used = 16'(n);
            end
            REQ_FREE_RGN: begin
                first = addr >> PG_SHIFT;
                last  = first + (len >> PG_SHIFT);
                stop  = (last > n) ? n : last;
                for (pg = first; pg < stop; pg++)
                    release_frame(pg);
                if (last > n)
                    r.status = ST_RANGE;
            end
            REQ_ALLOC: begin
                // lowest clear bit below the managed count
                for (int w = 0; w < MAP_WORDS && !hit && w * 32 < n; w++) begin
                    if (frame_map[w] != ALL_USED) begin
                        for (int b = 0; b < 32 && !hit; b++) begin
                            pg = w * 32 + b;
                            if (pg < n && !frame_map[w][b]) begin
                                hit = 1'b1;
                                frame_map[w][b] = 1'b1;
                                if (frames_used != 16'hFFFF)
                                    frames_used++;
                                r.page_addr = 32'(pg << PG_SHIFT);
                            end
                        end
                    end
                end
                if (!hit)
                    r.status = ST_OOM;
            end
            REQ_FREE_PAGE: begin
                pg = addr >> PG_SHIFT;
                if (pg >= n)
                    r.status = ST_RANGE;
                else
                    release_frame(pg);
            end
        endcase
        r.in_use = frames_used;
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Offer one request word and wait until it is taken
    task automatic send_request(logic [1:0] req, logic [31:0] addr, logic [31:0] len,
                                logic known, alloc_resp_t want);
        alloc_resp_t pred;
        int unsigned gap;
        if ($urandom_range(0, 29) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {len, addr};
        s_user  <= req;
        @(negedge i_clk);
        while (o_s_axis_tready !== 1'b1) @(negedge i_clk);
        @(posedge i_clk);
        pred = serve_request(req, addr, len);
        pending_resp.push_back(known ? want : pred);
        sent_total++;
        req_hits[req]++;
        if (pred.status == ST_RANGE)
            range_hits++;
        if (req == REQ_ALLOC) begin
            if (pred.status == ST_OK) begin
                alloc_ok++;
                held_pages.push_back(pred.page_addr >> PG_SHIFT);
            end else begin
                alloc_oom++;
            end
        end
    endtask

    // Write total_pages while the allocator is idle, then read it back
    task automatic program_total_pages(logic [15:0] value);
        // withdraw the last request word so it is not taken a second time
        s_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TOTAL_PAGES, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (pready !== 1'b1) @(negedge i_clk);
        @(posedge i_clk);
        total_pages_reg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (pready !== 1'b1) @(negedge i_clk);
        if (prdata[15:0] !== value)
            flag_mismatch("total_pages readback", {16'h0, value}, prdata);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One phase: refill, open a window of free pages, then mostly alloc/free traffic
    task automatic run_phase();
        int unsigned n;
        int unsigned pick;
        int unsigned pg;
        int unsigned span;
        int unsigned idx;
        n = managed_count();
        held_pages.delete();
        send_request(REQ_INIT, $urandom, $urandom, 1'b0, '0);
        span = (n > 200) ? 200 : n;
        send_request(REQ_FREE_RGN, 32'h0, 32'(span << PG_SHIFT) | $urandom_range(0, 4095),
                     1'b0, '0);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_request(REQ_ALLOC, $urandom, $urandom, 1'b0, '0);
            end else if (pick < 72) begin
                if (held_pages.size() != 0) begin
                    idx = $urandom_range(0, held_pages.size() - 1);
                    pg = held_pages[idx];
                    held_pages.delete(idx);
                end else begin
                    pg = $urandom_range(0, n + 8);
                end
                send_request(REQ_FREE_PAGE, 32'(pg << PG_SHIFT) | $urandom_range(0, 4095),
                             $urandom, 1'b0, '0);
            end else if (pick < 86) begin
                pg = $urandom_range(0, n + 40);
                span = $urandom_range(0, 40);
                send_request(REQ_FREE_RGN, 32'(pg << PG_SHIFT) | $urandom_range(0, 4095),
                             32'(span << PG_SHIFT) | $urandom_range(0, 4095), 1'b0, '0);
            end else if (pick < 93) begin
                send_request(REQ_FREE_PAGE, $urandom, $urandom, 1'b0, '0);
            end else if (pick < 98) begin
                send_request(REQ_FREE_RGN, $urandom, $urandom, 1'b0, '0);
            end else begin
                send_request(REQ_INIT, $urandom, $urandom, 1'b0, '0);
                held_pages.delete();
            end
        end
    endtask

    // Result sink: random stalls, one long hold-off, field-by-field check
    initial begin : result_sink
        alloc_resp_t want;
        int unsigned stall;
        logic [47:0] data;
        logic [1:0]  user;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!held_once && sent_total >= HOLD_AFTER) begin
                held_once = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if ($urandom_range(0, 29) == 0)
                    recv_calm = !recv_calm;
                stall = recv_calm ? 0 : $urandom_range(0, 8);
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_ready <= 1'b1;
            @(negedge i_clk);
            while (o_m_axis_tvalid !== 1'b1) @(negedge i_clk);
            data = o_m_axis_tdata;
            user = o_m_axis_tuser;
            @(posedge i_clk);
            words_seen++;
            if (pending_resp.size() == 0) begin
                flag_mismatch("unexpected result word", 32'h0, data[31:0]);
            end else begin
                want = pending_resp.pop_front();
                if (user !== want.status)
                    flag_mismatch("status", {30'h0, want.status}, {30'h0, user});
                if (data[31:0] !== want.page_addr)
                    flag_mismatch("page_address", want.page_addr, data[31:0]);
                if (data[47:32] !== want.in_use)
                    flag_mismatch("pages_in_use", {16'h0, want.in_use}, {16'h0, data[47:32]});
            end
        end
    end

    // Main sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int w = 0; w < MAP_WORDS; w++)
            frame_map[w] = ALL_USED;
        frames_used     = RESET_USED;
        total_pages_reg = RESET_TOTAL;

        for (int r = 0; r < DIR_ROWS; r++)
            send_request(directed_rows[r].req, directed_rows[r].addr, directed_rows[r].len,
                         directed_rows[r].known, directed_rows[r].resp);

        phase_pages[9] = 16'($urandom_range(2, 2048));
        for (int p = 0; p < PHASES; p++) begin
            program_total_pages(phase_pages[p]);
            run_phase();
        end

        s_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d requests (init %0d, free region %0d, alloc %0d, free page %0d)",
                 sent_total, req_hits[REQ_INIT], req_hits[REQ_FREE_RGN],
                 req_hits[REQ_ALLOC], req_hits[REQ_FREE_PAGE]);
        $display("%0d result words; %0d pages handed out, %0d out-of-memory, %0d range flags",
                 words_seen, alloc_ok, alloc_oom, range_hits);
        if (mismatches == 0)
            $display("tb_page_frame_bitmap_allocator: clean");
        else
            $display("tb_page_frame_bitmap_allocator: errors");
        $finish;
    end

endmodule
